/* sv/frms_pkg.sv */
package frms_pkg;

	// Field widths of the channels and registers.
	localparam int PULSE_W = 16;
	localparam int RATE_W  = 16;
	localparam int TOTAL_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int AVG_W = 4;

	// Register indexes on the write port.
	localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_LITRE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVG_SAMPLES       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_FLOW_THRESHOLD = 2'd2;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] PPL_RESET = 16'd450;
	localparam logic [AVG_W-1:0]      AVG_RESET = 4'd4;
	localparam logic [CFG_DATA_W-1:0] THR_RESET = 16'd0;

	// Seconds per minute and tenths per unit set the scale of rate and volume.
	localparam int SEC_PER_MIN = 60;
	localparam int TENTHS      = 10;
	localparam int RATE_SCALE  = SEC_PER_MIN * TENTHS;

	// A pulse count times RATE_SCALE fits in RAW_W bits.
	localparam int RAW_W = 26;

	// Shared serial divider: dividend, divisor and step counter widths.
	localparam int DVD_W  = 36;
	localparam int DVS_W  = 16;
	localparam int STEP_W = 6;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

endpackage

/* sv/frms_if.sv */
interface frms_in_if import frms_pkg::*;;
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_count;

	modport source(output valid, output pulse_count, input ready);
	modport sink(input valid, input pulse_count, output ready);
endinterface

interface frms_out_if import frms_pkg::*;;
	logic               valid;
	logic               ready;
	logic [RATE_W-1:0]  raw_rate_x10;
	logic [RATE_W-1:0]  smoothed_rate_x10;
	logic [TOTAL_W-1:0] total_litres_x10;

	modport source(output valid, output raw_rate_x10, output smoothed_rate_x10,
		output total_litres_x10, input ready);
	modport sink(input valid, input raw_rate_x10, input smoothed_rate_x10,
		input total_litres_x10, output ready);
endinterface

/* sv/frms_div.sv */
module frms_div import frms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	// Restoring division, one quotient bit per cycle. The dividend arrives
	// left-aligned, so when the step counter runs out the shift register holds
	// the quotient alone.
	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* sv/flow_meter_rate_smoother_core.sv */
// Channel   Dir  Handshake      Payload
// sample    in   valid/ready    pulse_count (16)
// result    out  valid/ready    raw_rate_x10 (16), smoothed_rate_x10 (16),
//                               total_litres_x10 (32)
// wr_*      in   wr_en only     wr_index (2), wr_data (16)
//
// One item is worked on at a time. The serial dividers retire one quotient bit
// per cycle. After the window is shortened, the ring pointer is folded back
// into it by repeated subtraction, one step per cycle, while the rate division
// runs; the item moves on only once the pointer lies in the window.
// The result sits in an output register, so a new item is taken while it
// waits. Reset clears the control state and the running total at once; the
// payload registers carry no reset, and the rate history reads as zero through
// per-slot valid bits.
module flow_meter_rate_smoother_core import frms_pkg::*; #(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	frms_in_if.sink               sample,
	frms_out_if.source            result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	// Pointer width, window width (can hold the depth itself) and sum width.
	localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int NW = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = RATE_W + $clog2(HISTORY_DEPTH);
	localparam logic [7:0] DEPTH_8 = 8'(HISTORY_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_DIVR  = 7'b0000100,
		ST_WRITE = 7'b0001000,
		ST_SUM   = 7'b0010000,
		ST_DIVA  = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] ppl_q;
	logic [AVG_W-1:0]      avg_q;
	logic [CFG_DATA_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q <= PPL_RESET;
			avg_q <= AVG_RESET;
			thr_q <= THR_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_PULSES_PER_LITRE:  ppl_q <= wr_data;
				REG_AVG_SAMPLES:       avg_q <= wr_data[AVG_W-1:0];
				REG_NO_FLOW_THRESHOLD: thr_q <= wr_data;
				default: ;
			endcase
		end
	end

	// A zero calibration counts as one; the window is clamped to 1..depth.
	logic [DVS_W-1:0] div_eff;
	logic [NW-1:0]    n_w;

	assign div_eff = (ppl_q == '0) ? DVS_W'(1) : ppl_q;

	always_comb begin
		if (avg_q == '0) begin
			n_w = NW'(1);
		end else if ({4'b0, avg_q} > DEPTH_8) begin
			n_w = NW'(HISTORY_DEPTH);
		end else begin
			n_w = NW'(avg_q);
		end
	end

	// Item state.
	logic [PULSE_W-1:0] pulse_q;
	logic [TOTAL_W-1:0] total_q;
	logic [RATE_W-1:0]  raw_q;
	logic [PW-1:0]      rp_q;
	logic [NW-1:0]      idx_q;
	logic [SUM_W-1:0]   sum_q;

	logic in_acc;
	assign sample.ready = (state_q == ST_IDLE);
	assign in_acc       = sample.valid && sample.ready;

	// Divider A runs the rate division and then the average; divider B runs
	// the volume division alongside them.
	div_ctl_t         ctl_a, ctl_b;
	logic [DVD_W-1:0] dvd_a, dvd_b, quo_a, quo_b;
	logic [DVS_W-1:0] dvs_a;
	logic             busy_a, busy_b;
	logic [RAW_W-1:0] scaled_pulses;
	logic             sum_done;

	assign scaled_pulses = RAW_W'(pulse_q) * RAW_W'(RATE_SCALE);

	always_comb begin
		ctl_a.start = (state_q == ST_LOAD) || sum_done;
		if (state_q == ST_LOAD) begin
			ctl_a.steps = STEP_W'(RAW_W);
			dvd_a       = DVD_W'(scaled_pulses) << (DVD_W - RAW_W);
			dvs_a       = div_eff;
		end else begin
			ctl_a.steps = STEP_W'(SUM_W);
			dvd_a       = DVD_W'(sum_q) << (DVD_W - SUM_W);
			dvs_a       = DVS_W'(n_w);
		end
		ctl_b.start = (state_q == ST_LOAD);
		ctl_b.steps = STEP_W'(DVD_W);
		dvd_b       = DVD_W'(total_q) * DVD_W'(TENTHS);
	end

	frms_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_a),
		.dividend (dvd_a),
		.divisor  (dvs_a),
		.busy     (busy_a),
		.quotient (quo_a)
	);

	frms_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_b),
		.dividend (dvd_b),
		.divisor  (div_eff),
		.busy     (busy_b),
		.quotient (quo_b)
	);

	// The rate saturates at the top of its 16-bit range.
	logic [RATE_W-1:0] raw_sat;
	assign raw_sat = (|quo_a[RAW_W-1:RATE_W]) ? '1 : quo_a[RATE_W-1:0];

	// The pointer is folded into the window by repeated subtraction while the
	// rate division runs.
	logic rp_in_range;
	logic rp_wrap;
	assign rp_in_range = NW'(rp_q) < n_w;
	assign rp_wrap     = (NW'(rp_q) + NW'(1)) == n_w;

	// Rate history: a memory with registered read, plus per-slot valid bits
	// that make never-written slots read as zero.
	logic [RATE_W-1:0]        hist_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic                     hist_we;
	logic                     rd_issue;
	logic [PW-1:0]            rd_idx;
	logic [RATE_W-1:0]        rd_data_s1;
	logic                     rd_vld_s1;
	logic                     rd_pend_s1;
	logic [RATE_W-1:0]        rd_val;

	assign hist_we  = (state_q == ST_WRITE);
	assign rd_issue = (state_q == ST_SUM) && (idx_q < n_w);
	assign rd_idx   = idx_q[PW-1:0];
	assign rd_val   = rd_vld_s1 ? rd_data_s1 : '0;
	assign sum_done = (state_q == ST_SUM) && (idx_q == n_w) && !rd_pend_s1;

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[rp_q] <= raw_q;
		end
		rd_data_s1 <= hist_mem[rd_idx];
		rd_vld_s1  <= hist_vld_q[rd_idx];
	end

	// Output register.
	logic               out_vld_q;
	logic [RATE_W-1:0]  out_raw_q;
	logic [RATE_W-1:0]  out_smooth_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_load;
	logic [RATE_W-1:0]  smooth;

	assign smooth   = (quo_a[RATE_W-1:0] < thr_q) ? '0 : quo_a[RATE_W-1:0];
	assign out_load = (state_q == ST_DIVA) && !busy_a && !busy_b &&
		(!out_vld_q || result.ready);

	assign result.valid             = out_vld_q;
	assign result.raw_rate_x10      = out_raw_q;
	assign result.smoothed_rate_x10 = out_smooth_q;
	assign result.total_litres_x10  = out_total_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DIVR;
			ST_DIVR:  if (!busy_a && rp_in_range) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_SUM;
			ST_SUM:   if (sum_done) state_d = ST_DIVA;
			ST_DIVA:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			rp_q       <= '0;
			idx_q      <= '0;
			sum_q      <= '0;
			hist_vld_q <= '0;
			rd_pend_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_issue;
			if (in_acc) begin
				total_q <= total_q + TOTAL_W'(sample.pulse_count);
			end
			if (state_q == ST_DIVR && !rp_in_range) begin
				rp_q <= PW'(NW'(rp_q) - n_w);
			end
			if (hist_we) begin
				hist_vld_q[rp_q] <= 1'b1;
				rp_q  <= rp_wrap ? '0 : rp_q + PW'(1);
				idx_q <= '0;
				sum_q <= '0;
			end
			if (rd_issue) begin
				idx_q <= idx_q + NW'(1);
			end
			if (rd_pend_s1) begin
				sum_q <= sum_q + SUM_W'(rd_val);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pulse_q <= sample.pulse_count;
		end
		if (state_q == ST_DIVR && !busy_a) begin
			raw_q <= raw_sat;
		end
		if (out_load) begin
			out_raw_q    <= raw_q;
			out_smooth_q <= smooth;
			out_total_q  <= quo_b[TOTAL_W-1:0];
		end
	end

endmodule

/* sv/frms_chk.sv */
module frms_chk import frms_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [RATE_W-1:0]  raw_rate_x10,
	input logic [RATE_W-1:0]  smoothed_rate_x10,
	input logic [TOTAL_W-1:0] total_litres_x10
);

	// Only one item is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in work");

	// A new result appears only as the block returns to taking items.
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while the input was still blocked");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(raw_rate_x10) &&
			$stable(smoothed_rate_x10) && $stable(total_litres_x10))
		else $error("result fields changed while stalled");

endmodule

bind flow_meter_rate_smoother_core frms_chk u_frms_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (sample.valid),
	.in_ready          (sample.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.raw_rate_x10      (result.raw_rate_x10),
	.smoothed_rate_x10 (result.smoothed_rate_x10),
	.total_litres_x10  (result.total_litres_x10)
);
